FILE: design/qmwag_pkg.sv
// ----------------------------------------------------------------------------
// qmwag_pkg
// shared types and constants of the quadrant-mirrored warp address generator
// ----------------------------------------------------------------------------
`default_nettype none

package qmwag_pkg;

  localparam int unsigned ADDR_W      = 16;
  localparam int unsigned TEX_W       = 8;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned NUM_CMD     = 4;
  localparam int unsigned CMD_IDX_W   = 2;

  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_X = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_OFFSET_Y = 2'd1;

  localparam logic [CMD_IDX_W-1:0] CMD_UL = 2'd0;
  localparam logic [CMD_IDX_W-1:0] CMD_UR = 2'd1;
  localparam logic [CMD_IDX_W-1:0] CMD_LL = 2'd2;
  localparam logic [CMD_IDX_W-1:0] CMD_LR = 2'd3;

  typedef struct packed {
    logic              end_of_frame;
    logic              last_of_entry;
    logic [ADDR_W-1:0] texel_address;
    logic [ADDR_W-1:0] pixel_address;
  } cmd_t;

  typedef struct packed {
    logic [ADDR_W-1:0] base_up;
    logic [ADDR_W-1:0] base_dn;
    logic [ADDR_W-1:0] col_lf;
    logic [ADDR_W-1:0] col_rt;
    logic              eof;
  } pos_t;

endpackage

`default_nettype wire

FILE: design/quadrant_mirrored_warp_address_gen.sv
// ----------------------------------------------------------------------------
// quadrant_mirrored_warp_address_gen
// turns first-quadrant warp table entries into mirrored frame-write commands
// ----------------------------------------------------------------------------
// Input stream s_axis: one table entry per request, first quadrant in
// row-major order, starting on the centre pixel. Output stream m_axis: four
// commands per entry (upper-left, upper-right, lower-left, lower-right),
// tlast on the fourth, tuser high on all commands of the last entry of a frame.
// Config channel: cfg_index_i 0 is offset_x, 1 is offset_y; other indexes are
// dropped. Write only while the block is idle.
// An entry lands in the input register, then its four commands are loaded
// together into the command buffer, which issues them one by one. Entry
// throughput is set by the single output port issuing one command a cycle
// while the receiver is ready. The input register takes the next entry
// while the command buffer drains. Reset clears offsets, counters and all
// valid flags. A stalled receiver holds the current command; the input side
// stops once the input register is full.
// ----------------------------------------------------------------------------
`default_nettype none

module quadrant_mirrored_warp_address_gen #(
  parameter int unsigned FRAME_WIDTH  = 320,
  parameter int unsigned FRAME_HEIGHT = 200
) (
  input  var logic        clk_i,
  input  var logic        rst_ni,
  // config write channel
  input  var logic        cfg_valid_i,
  output logic            cfg_ready_o,
  input  var logic [qmwag_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  var logic [qmwag_pkg::TEX_W-1:0]     cfg_data_i,
  // table entries
  input  var logic        s_axis_tvalid,
  output logic            s_axis_tready,
  input  var logic [15:0] s_axis_tdata,   // disp_x[7:0], disp_y[15:8]
  // frame-write commands
  output logic            m_axis_tvalid,
  input  var logic        m_axis_tready,
  output logic [31:0]     m_axis_tdata,   // pixel_address[15:0], texel_address[31:16]
  output logic            m_axis_tlast,   // last_of_entry
  output logic            m_axis_tuser    // end_of_frame
);

  localparam int unsigned HALF_W = FRAME_WIDTH / 2;
  localparam int unsigned HALF_H = FRAME_HEIGHT / 2;
  localparam int unsigned COL_W  = $clog2(HALF_W);
  localparam int unsigned ROW_W  = $clog2(HALF_H);
  localparam logic [COL_W-1:0] COL_LAST = COL_W'(HALF_W - 1);
  localparam logic [ROW_W-1:0] ROW_LAST = ROW_W'(HALF_H - 1);
  localparam logic [qmwag_pkg::ADDR_W-1:0] HALF_W16 = qmwag_pkg::ADDR_W'(HALF_W);
  localparam logic [qmwag_pkg::ADDR_W-1:0] FW16     = qmwag_pkg::ADDR_W'(FRAME_WIDTH % 65536);
  localparam logic [qmwag_pkg::ADDR_W-1:0] BASE0    =
      qmwag_pkg::ADDR_W'((HALF_H * FRAME_WIDTH) % 65536);

  logic [qmwag_pkg::TEX_W-1:0] offset_x_q, offset_y_q;

  logic                        in_valid_q;
  logic [qmwag_pkg::TEX_W-1:0] disp_x_q, disp_y_q;

  logic [COL_W-1:0]            col_q;
  logic [ROW_W-1:0]            row_q;
  logic [qmwag_pkg::ADDR_W-1:0] base_up_q, base_dn_q;

  logic                        out_valid_q;
  logic [qmwag_pkg::CMD_IDX_W-1:0] idx_q;
  qmwag_pkg::cmd_t             cmd_q [qmwag_pkg::NUM_CMD];
  qmwag_pkg::cmd_t             cmd_d [qmwag_pkg::NUM_CMD];
  qmwag_pkg::cmd_t             cur_cmd;
  qmwag_pkg::pos_t             pos;

  logic s_fire, m_fire, drain_last, load_cmd, col_wrap, row_wrap;

  assign cfg_ready_o = 1'b1;

  assign m_fire     = out_valid_q && m_axis_tready;
  assign drain_last = m_fire && (idx_q == qmwag_pkg::CMD_LR);
  assign load_cmd   = in_valid_q && (!out_valid_q || drain_last);
  assign s_axis_tready = !in_valid_q || load_cmd;
  assign s_fire     = s_axis_tvalid && s_axis_tready;
  assign col_wrap   = (col_q == COL_LAST);
  assign row_wrap   = (row_q == ROW_LAST);

  always_comb begin
    pos.base_up = base_up_q;
    pos.base_dn = base_dn_q;
    pos.col_lf  = HALF_W16 - qmwag_pkg::ADDR_W'(col_q);
    pos.col_rt  = HALF_W16 + qmwag_pkg::ADDR_W'(col_q);
    pos.eof     = col_wrap && row_wrap;
  end

  qmwag_cmd_calc u_calc (
    .disp_x_i   (disp_x_q),
    .disp_y_i   (disp_y_q),
    .offset_x_i (offset_x_q),
    .offset_y_i (offset_y_q),
    .pos_i      (pos),
    .cmd_o      (cmd_d)
  );

  // configuration
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      offset_x_q <= '0;
      offset_y_q <= '0;
    end else if (cfg_valid_i) begin
      if (cfg_index_i == qmwag_pkg::REG_OFFSET_X) begin
        offset_x_q <= cfg_data_i;
      end else if (cfg_index_i == qmwag_pkg::REG_OFFSET_Y) begin
        offset_y_q <= cfg_data_i;
      end
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_fire) begin
      in_valid_q <= 1'b1;
    end else if (load_cmd) begin
      in_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      disp_x_q <= s_axis_tdata[7:0];
      disp_y_q <= s_axis_tdata[15:8];
    end
  end

  // position counters and row base addresses
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q     <= '0;
      row_q     <= '0;
      base_up_q <= BASE0;
      base_dn_q <= BASE0;
    end else if (load_cmd) begin
      if (col_wrap) begin
        col_q <= '0;
        if (row_wrap) begin
          row_q     <= '0;
          base_up_q <= BASE0;
          base_dn_q <= BASE0;
        end else begin
          row_q     <= row_q + 1'b1;
          base_up_q <= base_up_q - FW16;
          base_dn_q <= base_dn_q + FW16;
        end
      end else begin
        col_q <= col_q + 1'b1;
      end
    end
  end

  // command buffer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= qmwag_pkg::CMD_UL;
    end else if (load_cmd) begin
      out_valid_q <= 1'b1;
      idx_q       <= qmwag_pkg::CMD_UL;
    end else if (drain_last) begin
      out_valid_q <= 1'b0;
    end else if (m_fire) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_cmd) begin
      cmd_q <= cmd_d;
    end
  end

  assign cur_cmd       = cmd_q[idx_q];
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {cur_cmd.texel_address, cur_cmd.pixel_address};
  assign m_axis_tlast  = cur_cmd.last_of_entry;
  assign m_axis_tuser  = cur_cmd.end_of_frame;

  // checks
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (col_q <= COL_LAST) && (row_q <= ROW_LAST))
    else $error("position counter out of range");

  a_frame_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_cmd && pos.eof |=> (col_q == '0) && (row_q == '0) && (base_up_q == BASE0))
    else $error("frame end did not restart the walk");

  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !m_axis_tready && !load_cmd |=> out_valid_q && $stable(idx_q))
    else $error("command index moved during stall");

  a_refill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && drain_last |=> out_valid_q && (idx_q == qmwag_pkg::CMD_UL))
    else $error("pending entry not loaded after drain");

endmodule

`default_nettype wire

FILE: design/qmwag_cmd_calc.sv
// ----------------------------------------------------------------------------
// qmwag_cmd_calc
// builds the four mirrored frame-write commands of one table entry
// ----------------------------------------------------------------------------
`default_nettype none

module qmwag_cmd_calc (
  input  var logic [qmwag_pkg::TEX_W-1:0] disp_x_i,
  input  var logic [qmwag_pkg::TEX_W-1:0] disp_y_i,
  input  var logic [qmwag_pkg::TEX_W-1:0] offset_x_i,
  input  var logic [qmwag_pkg::TEX_W-1:0] offset_y_i,
  input  var qmwag_pkg::pos_t             pos_i,
  output qmwag_pkg::cmd_t                 cmd_o [qmwag_pkg::NUM_CMD]
);

  logic [qmwag_pkg::TEX_W-1:0] tr_minus, tr_plus, tc_minus, tc_plus;

  always_comb begin
    tr_minus = offset_y_i - disp_y_i;
    tr_plus  = offset_y_i + disp_y_i;
    tc_minus = offset_x_i - disp_x_i;
    tc_plus  = offset_x_i + disp_x_i;

    // upper-left
    cmd_o[qmwag_pkg::CMD_UL].pixel_address = pos_i.base_up + pos_i.col_lf;
    cmd_o[qmwag_pkg::CMD_UL].texel_address = {tr_minus, tc_minus};
    cmd_o[qmwag_pkg::CMD_UL].last_of_entry = 1'b0;
    cmd_o[qmwag_pkg::CMD_UL].end_of_frame  = pos_i.eof;
    // upper-right
    cmd_o[qmwag_pkg::CMD_UR].pixel_address = pos_i.base_up + pos_i.col_rt;
    cmd_o[qmwag_pkg::CMD_UR].texel_address = {tr_plus, tc_minus};
    cmd_o[qmwag_pkg::CMD_UR].last_of_entry = 1'b0;
    cmd_o[qmwag_pkg::CMD_UR].end_of_frame  = pos_i.eof;
    // lower-left
    cmd_o[qmwag_pkg::CMD_LL].pixel_address = pos_i.base_dn + pos_i.col_lf;
    cmd_o[qmwag_pkg::CMD_LL].texel_address = {tr_minus, tc_plus};
    cmd_o[qmwag_pkg::CMD_LL].last_of_entry = 1'b0;
    cmd_o[qmwag_pkg::CMD_LL].end_of_frame  = pos_i.eof;
    // lower-right
    cmd_o[qmwag_pkg::CMD_LR].pixel_address = pos_i.base_dn + pos_i.col_rt;
    cmd_o[qmwag_pkg::CMD_LR].texel_address = {tr_plus, tc_plus};
    cmd_o[qmwag_pkg::CMD_LR].last_of_entry = 1'b1;
    cmd_o[qmwag_pkg::CMD_LR].end_of_frame  = pos_i.eof;
  end

endmodule

`default_nettype wire
